/* src/b2c_pkg.sv */
// Shared types and constants for the byte to coefficient bit packer.
// Holds the item structs of both channels and the step result struct.
// No dependencies.
`default_nettype none

package b2c_pkg;

    // Bits in one input byte, and the counter width that holds 0 to 8.
    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned REM_W     = 4;

    // Coefficient and width register sizes.
    localparam int unsigned COEFF_W   = 64;
    localparam int unsigned WIDTH_W   = 7;

    // Width register value after reset, and the range it is clamped to.
    localparam logic [WIDTH_W-1:0] RESET_WIDTH = 7'd60;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH   = 7'd1;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 7'd64;

    // One input item: a byte and its end-of-element marker.
    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 last_byte;
    } byte_item_t;

    // One result item: a packed coefficient and its end-of-element marker.
    typedef struct packed {
        logic [COEFF_W-1:0] coefficient;
        logic               last_coeff;
    } coeff_item_t;

    // Result of one step of the packing datapath.
    typedef struct packed {
        logic                 emit;
        logic                 last_out;
        logic [COEFF_W-1:0]   coeff;
        logic [COEFF_W-1:0]   acc_next;
        logic [WIDTH_W-1:0]   held_next;
        logic [BYTE_BITS-1:0] byte_next;
        logic [REM_W-1:0]     rem_next;
    } step_t;

endpackage

`default_nettype wire

/* src/b2c_step.sv */
// One step of the packer: moves up to one coefficient's worth of bits from
// the held byte into the accumulator and decides whether a coefficient leaves.
// Depends on b2c_pkg.
`default_nettype none

module b2c_step
    import b2c_pkg::*;
(
    input  wire logic [COEFF_W-1:0]   acc,
    input  wire logic [WIDTH_W-1:0]   held,
    input  wire logic [BYTE_BITS-1:0] byte_bits,
    input  wire logic [REM_W-1:0]     rem,
    input  wire logic                 last,
    input  wire logic [WIDTH_W-1:0]   width_raw,
    output step_t                     st
);

    logic [WIDTH_W-1:0]   eff_width;
    logic [WIDTH_W-1:0]   need;
    logic                 take_full;
    logic [REM_W-1:0]     take;
    logic [BYTE_BITS-1:0] top_bits;
    logic [COEFF_W-1:0]   shifted;
    logic [WIDTH_W-1:0]   held_sum;
    logic [5:0]           flush_shift;
    logic [WIDTH_W-1:0]   flush_diff;

    // Clamp the configured width to 1..64.
    always_comb
    begin
        if (width_raw == '0)
            eff_width = MIN_WIDTH;
        else if (width_raw > MAX_WIDTH)
            eff_width = MAX_WIDTH;
        else
            eff_width = width_raw;
    end

    // Take either the bits that complete a coefficient or all remaining bits.
    always_comb
    begin
        if (held >= eff_width)
            need = 7'd1;
        else
            need = eff_width - held;
        take_full   = (need <= {3'b000, rem});
        take        = take_full ? need[REM_W-1:0] : rem;
        top_bits    = byte_bits >> (REM_W'(BYTE_BITS) - take);
        shifted     = (acc << take) | {{(COEFF_W-BYTE_BITS){1'b0}}, top_bits};
        held_sum    = held + {3'b000, take};
        flush_diff  = eff_width - held_sum;
        flush_shift = flush_diff[5:0];
    end

    // Form the step result: a full coefficient, a flush, or plain absorption.
    always_comb
    begin
        st.emit      = 1'b0;
        st.last_out  = 1'b0;
        st.coeff     = shifted;
        st.acc_next  = shifted;
        st.held_next = held_sum;
        st.byte_next = byte_bits << take;
        st.rem_next  = rem - take;
        if (take_full)
        begin
            st.emit      = 1'b1;
            st.last_out  = last && (st.rem_next == '0);
            st.acc_next  = '0;
            st.held_next = '0;
        end
        else if (last)
        begin
            // The element ends with a partial coefficient: pad its low bits.
            st.emit      = 1'b1;
            st.last_out  = 1'b1;
            st.coeff     = shifted << flush_shift;
            st.acc_next  = '0;
            st.held_next = '0;
        end
    end

endmodule

`default_nettype wire

/* src/byte_to_coeff_bit_packer.sv */
// Top level of the byte to coefficient bit packer (8 to N gearbox).
// Instantiates b2c_step; depends on b2c_pkg.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+--------------------------
//  byte      | in        | byte_valid / byte_stall | byte_item  (byte_item_t)
//  coeff     | out       | coeff_valid/ coeff_stall| coeff_item (coeff_item_t)
//  cfg       | in        | cfg_we                  | cfg_data   (coeff width)
//
// A byte enters the byte register, then in each cycle in which the output has
// room for any coefficient it emits, one step either absorbs all of its
// remaining bits or completes one coefficient into the output register. A byte
// takes one step for each coefficient it completes, plus one for any bits left
// after the last of them. The byte register reloads in the cycle of the final
// step, so one-step bytes follow back to back. A coefficient is valid in the
// cycle after its step; a byte's first step runs from the byte register once
// the byte is accepted. Reset clears the accumulator, the bit count, the
// pending byte bits and the output valid flag, and sets the width to 60.
// A stalled output holds its item; steps that emit wait for it, so the
// byte side stalls in turn.
`default_nettype none

module byte_to_coeff_bit_packer
    import b2c_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [WIDTH_W-1:0] cfg_data,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire byte_item_t         byte_item,
    output logic                    coeff_valid,
    input  wire logic               coeff_stall,
    output coeff_item_t             coeff_item
);

    logic [WIDTH_W-1:0]   width_reg;
    logic [COEFF_W-1:0]   acc_reg;
    logic [WIDTH_W-1:0]   held_reg;
    logic [BYTE_BITS-1:0] byte_reg;
    logic [REM_W-1:0]     rem_reg;
    logic                 last_reg;
    logic                 out_valid_reg;
    coeff_item_t          out_item_reg;

    step_t st;
    logic  out_free;
    logic  step_go;
    logic  byte_done;
    logic  byte_take;

    // Step datapath.
    b2c_step u_step (
        .acc       (acc_reg),
        .held      (held_reg),
        .byte_bits (byte_reg),
        .rem       (rem_reg),
        .last      (last_reg),
        .width_raw (width_reg),
        .st        (st)
    );

    // Handshake control: a step runs when it has bits and room for its result.
    always_comb
    begin
        out_free   = !out_valid_reg || !coeff_stall;
        step_go    = (rem_reg != '0) && (!st.emit || out_free);
        byte_done  = (rem_reg == '0) || (step_go && (st.rem_next == '0));
        byte_take  = byte_valid && byte_done;
        byte_stall = !byte_done;
    end

    // Width register and packing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RESET_WIDTH;
            acc_reg       <= '0;
            held_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                width_reg <= cfg_data;
            if (step_go)
            begin
                acc_reg  <= st.acc_next;
                held_reg <= st.held_next;
            end
            if (byte_take)
                rem_reg <= REM_W'(BYTE_BITS);
            else if (step_go)
                rem_reg <= st.rem_next;
            if (step_go && st.emit)
                out_valid_reg <= 1'b1;
            else if (!coeff_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers for the held byte and the outgoing item.
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            byte_reg <= byte_item.data_byte;
            last_reg <= byte_item.last_byte;
        end
        else if (step_go)
        begin
            byte_reg <= st.byte_next;
        end
        if (step_go && st.emit)
        begin
            out_item_reg.coefficient <= st.coeff;
            out_item_reg.last_coeff  <= st.last_out;
        end
    end

    assign coeff_valid = out_valid_reg;
    assign coeff_item  = out_item_reg;

    // A newly accepted byte starts with all eight bits pending.
    a_byte_load: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall |=> rem_reg == REM_W'(BYTE_BITS))
        else $error("accepted byte not loaded with full bit count");

    // An emitting step never overwrites a result that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && st.emit |-> !(out_valid_reg && coeff_stall))
        else $error("result register overwritten while stalled");

    // The end of an element leaves the accumulator empty.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && st.emit && st.last_out |=> held_reg == '0 && acc_reg == '0)
        else $error("accumulator not cleared after last coefficient");

    // The stored bit count stays below 64 bits.
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg < MAX_WIDTH && rem_reg <= REM_W'(BYTE_BITS))
        else $error("bit count out of range");

endmodule

`default_nettype wire
